@@ rtl/core/dbed_pkg.sv @@
`default_nettype none
package dbed_pkg;

  localparam int DICT_DEPTH = 256;
  localparam int VALUE_BITS = 64;
  localparam int IDX_W      = $clog2(DICT_DEPTH);
  localparam int SIZE_W     = $clog2(DICT_DEPTH + 1);
  localparam int CNT_W      = 32;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_TRAIN  = 3'd1;
  localparam logic [2:0] CMD_SORT   = 3'd2;
  localparam logic [2:0] CMD_ENCODE = 3'd3;
  localparam logic [2:0] CMD_DECODE = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [63:0] value;
    logic [7:0]         code;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         code_out;
    logic signed [63:0] value_out;
    logic               found;
    logic               block_end;
    logic [8:0]         entries;
  } out_beat_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_SORT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              odd;
    logic [SIZE_W-1:0] size;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SORT,
    ST_DECIDE,
    ST_SCAN2,
    ST_DONE
  } state_t;

  function automatic logic [63:0] sext(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = (i < VALUE_BITS) ? v[i] : v[VALUE_BITS-1];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/dbed_cell.sv @@
`default_nettype none
module dbed_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dbed_pkg::cell_ctl_t           ctl,
  input  wire logic [dbed_pkg::IDX_W-1:0]    my_idx,
  input  wire logic [63:0]                   left_val,
  input  wire logic [dbed_pkg::CNT_W-1:0]    left_cnt,
  input  wire logic [63:0]                   right_val,
  input  wire logic [dbed_pkg::CNT_W-1:0]    right_cnt,
  output logic [63:0]                        val,
  output logic [dbed_pkg::CNT_W-1:0]         cnt
);

  logic [dbed_pkg::SIZE_W-1:0] pos;
  logic                        is_lower;
  logic                        is_upper;
  logic                        take_right;
  logic                        take_left;

  always_comb begin
    pos        = dbed_pkg::SIZE_W'(my_idx);
    is_lower   = (my_idx[0] == ctl.odd) && ((pos + 1'b1) < ctl.size);
    is_upper   = (my_idx != '0) && (my_idx[0] != ctl.odd) && (pos < ctl.size);
    take_right = is_lower && ($signed(val) > $signed(right_val));
    take_left  = is_upper && ($signed(left_val) > $signed(val));
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      dbed_pkg::CELL_SHIFT: begin
        val <= right_val;
      end
      dbed_pkg::CELL_SORT: begin
        if (take_right) begin
          val <= right_val;
        end else if (take_left) begin
          val <= left_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (ctl.op)
        dbed_pkg::CELL_SHIFT: cnt <= right_cnt;
        dbed_pkg::CELL_CLEAR: cnt <= '0;
        dbed_pkg::CELL_SORT: begin
          if (take_right) begin
            cnt <= right_cnt;
          end else if (take_left) begin
            cnt <= left_cnt;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dictionary_build_encode_decode_unit.sv @@
`default_nettype none
// channel   direction  handshake          beat
// in        input      in_valid/in_stall  command, value, code
// out       output     out_valid/out_stall code_out, value_out, found, block_end, entries
// cfg       input      cfg_valid/cfg_ready max_run
//
// train makes two passes over the cell ring, encode and decode one; clear and unused
// commands make none. train, encode and decode rotate the cell ring once per pass past
// the head compare; sort runs DICT_DEPTH odd-even rounds in the cells.
// one item at a time; a finished beat waits in the output register while the next
// item is taken. rst is synchronous: counts, size, run and max_run return to reset.
module dictionary_build_encode_decode_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dbed_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dbed_pkg::out_beat_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);

  localparam int D = dbed_pkg::DICT_DEPTH;

  dbed_pkg::state_t    state;
  dbed_pkg::state_t    state_next;
  dbed_pkg::cell_ctl_t ctl;

  logic [63:0]                 cval [D];
  logic [dbed_pkg::CNT_W-1:0]  ccnt [D];
  logic [63:0]                 wrap_val;
  logic [dbed_pkg::CNT_W-1:0]  wrap_cnt;

  logic [dbed_pkg::IDX_W-1:0]  idx;
  logic [dbed_pkg::SIZE_W-1:0] size;
  logic [dbed_pkg::SIZE_W-1:0] size_next;
  logic [15:0]                 run_count;
  logic [15:0]                 max_run;
  logic [2:0]                  cmd;
  logic [63:0]                 key;
  logic [7:0]                  code;
  logic                        hit;
  logic [dbed_pkg::IDX_W-1:0]  hit_idx;
  logic [dbed_pkg::CNT_W-1:0]  hit_cnt;
  logic [dbed_pkg::CNT_W-1:0]  min_cnt;
  logic [dbed_pkg::IDX_W-1:0]  min_idx;
  logic [63:0]                 cap_val;
  logic [dbed_pkg::IDX_W-1:0]  wr_idx;
  logic [63:0]                 wr_val;
  logic [dbed_pkg::CNT_W-1:0]  wr_cnt;
  dbed_pkg::out_beat_t         res;
  dbed_pkg::out_beat_t         res_next;
  logic                        accept;
  logic                        last;
  logic                        in_range;
  logic                        head_hit;
  logic [16:0]                 run_inc;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign last      = (idx == dbed_pkg::IDX_W'(D - 1));
  assign in_range  = (dbed_pkg::SIZE_W'(idx) < size);
  assign head_hit  = !hit && in_range && (cval[0] == key);
  assign run_inc   = {1'b0, run_count} + 17'd1;

  generate
    for (genvar k = 0; k < D; k++) begin : g_cell
      dbed_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .my_idx    (dbed_pkg::IDX_W'(k)),
        .left_val  (cval[(k + D - 1) % D]),
        .left_cnt  (ccnt[(k + D - 1) % D]),
        .right_val ((k == D - 1) ? wrap_val : cval[(k + 1) % D]),
        .right_cnt ((k == D - 1) ? wrap_cnt : ccnt[(k + 1) % D]),
        .val       (cval[k]),
        .cnt       (ccnt[k])
      );
    end
  endgenerate

  always_comb begin
    wrap_val = cval[0];
    wrap_cnt = ccnt[0];
    if (state == dbed_pkg::ST_SCAN2 && idx == wr_idx) begin
      wrap_val = wr_val;
      wrap_cnt = wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbed_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ctl.op     = dbed_pkg::CELL_HOLD;
    ctl.odd    = idx[0];
    ctl.size   = size;
    unique case (state)
      dbed_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          priority case (in_data.command)
            dbed_pkg::CMD_CLEAR: begin
              ctl.op     = dbed_pkg::CELL_CLEAR;
              state_next = dbed_pkg::ST_DECIDE;
            end
            dbed_pkg::CMD_SORT:   state_next = dbed_pkg::ST_SORT;
            dbed_pkg::CMD_TRAIN,
            dbed_pkg::CMD_ENCODE,
            dbed_pkg::CMD_DECODE: state_next = dbed_pkg::ST_SCAN1;
            default:              state_next = dbed_pkg::ST_DECIDE;
          endcase
        end
      end
      dbed_pkg::ST_SCAN1: begin
        ctl.op = dbed_pkg::CELL_SHIFT;
        if (last) begin
          state_next = dbed_pkg::ST_DECIDE;
        end
      end
      dbed_pkg::ST_SORT: begin
        ctl.op = dbed_pkg::CELL_SORT;
        if (last) begin
          state_next = dbed_pkg::ST_DECIDE;
        end
      end
      dbed_pkg::ST_DECIDE: begin
        state_next = (cmd == dbed_pkg::CMD_TRAIN) ? dbed_pkg::ST_SCAN2 : dbed_pkg::ST_DONE;
      end
      dbed_pkg::ST_SCAN2: begin
        ctl.op = dbed_pkg::CELL_SHIFT;
        if (last) begin
          state_next = dbed_pkg::ST_DONE;
        end
      end
      dbed_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = dbed_pkg::ST_IDLE;
        end
      end
      default: state_next = dbed_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    size_next = size;
    if (cmd == dbed_pkg::CMD_TRAIN && !hit && size < dbed_pkg::SIZE_W'(D)) begin
      size_next = size + 1'b1;
    end
  end

  always_comb begin
    res_next         = '0;
    res_next.entries = 9'(size_next);
    unique case (cmd)
      dbed_pkg::CMD_TRAIN: begin
        if (hit) begin
          res_next.code_out = 8'(hit_idx);
        end else if (size < dbed_pkg::SIZE_W'(D)) begin
          res_next.code_out = 8'(size);
        end else begin
          res_next.code_out = 8'(min_idx);
        end
      end
      dbed_pkg::CMD_ENCODE: begin
        res_next.found     = hit;
        res_next.code_out  = hit ? 8'(hit_idx) : 8'd0;
        res_next.block_end = !hit || (run_inc >= {1'b0, max_run});
      end
      dbed_pkg::CMD_DECODE: begin
        if (dbed_pkg::SIZE_W'(code) < size && {1'b0, code} < 9'(size)) begin
          res_next.value_out = dbed_pkg::sext(cap_val);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= '0;
      run_count <= '0;
      max_run   <= 16'hFFFF;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_run <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        dbed_pkg::ST_IDLE: begin
          idx <= '0;
          if (accept && in_data.command == dbed_pkg::CMD_CLEAR) begin
            size      <= '0;
            run_count <= '0;
          end
        end
        dbed_pkg::ST_SCAN1, dbed_pkg::ST_SORT, dbed_pkg::ST_SCAN2: begin
          idx <= last ? '0 : idx + 1'b1;
        end
        dbed_pkg::ST_DECIDE: begin
          size <= size_next;
          if (cmd == dbed_pkg::CMD_ENCODE) begin
            if (!hit || run_inc >= {1'b0, max_run}) begin
              run_count <= '0;
            end else begin
              run_count <= run_inc[15:0];
            end
          end
        end
        dbed_pkg::ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= in_data.command;
      key  <= dbed_pkg::sext(in_data.value);
      code <= in_data.code;
      hit  <= 1'b0;
    end
    if (state == dbed_pkg::ST_SCAN1) begin
      if (head_hit) begin
        hit     <= 1'b1;
        hit_idx <= idx;
        hit_cnt <= ccnt[0];
      end
      if (idx == '0 || ccnt[0] < min_cnt) begin
        min_cnt <= ccnt[0];
        min_idx <= idx;
      end
      if (8'(idx) == code) begin
        cap_val <= cval[0];
      end
    end
    if (state == dbed_pkg::ST_DECIDE) begin
      res <= res_next;
      if (cmd == dbed_pkg::CMD_TRAIN) begin
        wr_val <= key;
        if (hit) begin
          wr_idx <= hit_idx;
          wr_cnt <= (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
        end else if (size < dbed_pkg::SIZE_W'(D)) begin
          wr_idx <= dbed_pkg::IDX_W'(size);
          wr_cnt <= dbed_pkg::CNT_W'(1);
        end else begin
          wr_idx <= min_idx;
          wr_cnt <= dbed_pkg::CNT_W'(1);
        end
      end
    end
    if (state == dbed_pkg::ST_DONE && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dbed_checker.sv @@
`default_nettype none
module dbed_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire dbed_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled out beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_entries_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entries <= 9'(dbed_pkg::DICT_DEPTH))
    else $error("entries beyond depth");

  a_found_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> {1'b0, out_data.code_out} < out_data.entries)
    else $error("found code outside dictionary");

endmodule

bind dictionary_build_encode_decode_unit dbed_checker u_dbed_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
